[rtl/vna_pkg.sv]
// Shared types, constants and helpers for the vertex normal accumulator.
package vna_pkg;

	localparam int VERTEX_DEPTH = 1024;
	localparam int ADDR_W = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
	localparam int IDX_W = 10;

	typedef enum logic [1:0] {
		KIND_LOAD = 2'd0,
		KIND_TRI  = 2'd1,
		KIND_READ = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RDA,
		ST_RDB,
		ST_RDC,
		ST_EDGE,
		ST_CROSS,
		ST_RDS,
		ST_LDS,
		ST_MAG,
		ST_SHIFT,
		ST_SQ,
		ST_SQRT,
		ST_DINIT,
		ST_DIV,
		ST_RMW_RD,
		ST_RMW_WR
	} state_t;

	typedef struct packed {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic signed [23:0] z;
	} vec3_t;

	typedef struct packed {
		logic             pos_we;
		logic             sum_we;
		logic [IDX_W-1:0] pos_waddr;
		logic [IDX_W-1:0] pos_raddr;
		logic [IDX_W-1:0] sum_waddr;
		logic [IDX_W-1:0] sum_raddr;
		vec3_t            pos_wdata;
		vec3_t            sum_wdata;
	} store_req_t;

	function automatic logic idx_ok(input logic [IDX_W-1:0] i);
		return (32'(i) < VERTEX_DEPTH);
	endfunction

	function automatic logic signed [23:0] sat_add(input logic signed [23:0] a,
		input logic signed [15:0] b);
		logic signed [24:0] s;
		s = 25'(a) + 25'(b);
		if (s > 25'sd8388607) return 24'sd8388607;
		if (s < -25'sd8388608) return -24'sd8388608;
		return s[23:0];
	endfunction

endpackage

[rtl/vna_mul.sv]
// Shared registered signed multiplier used for cross products and squares.
module vna_mul (
	input  logic               clk,
	input  logic signed [30:0] a,
	input  logic signed [30:0] b,
	output logic signed [61:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

[rtl/vna_store.sv]
// Per-vertex position and normal-sum memories with registered reads.
module vna_store (
	input  logic                clk,
	input  vna_pkg::store_req_t req,
	output vna_pkg::vec3_t      pos_rd_q,
	output vna_pkg::vec3_t      sum_rd_q
);

	vna_pkg::vec3_t pos_mem [vna_pkg::VERTEX_DEPTH];
	vna_pkg::vec3_t sum_mem [vna_pkg::VERTEX_DEPTH];

	always_ff @(posedge clk) begin
		if (req.pos_we) begin
			pos_mem[vna_pkg::ADDR_W'(req.pos_waddr)] <= req.pos_wdata;
		end
		pos_rd_q <= pos_mem[vna_pkg::ADDR_W'(req.pos_raddr)];
	end

	always_ff @(posedge clk) begin
		if (req.sum_we) begin
			sum_mem[vna_pkg::ADDR_W'(req.sum_waddr)] <= req.sum_wdata;
		end
		sum_rd_q <= sum_mem[vna_pkg::ADDR_W'(req.sum_raddr)];
	end

endmodule

[rtl/vertex_normal_accumulator_top.sv]
// Top level: sequencer and datapath of the smooth vertex normal accumulator.
//
//  channel  | handshake          | word
//  ---------+--------------------+------------------------------------------------
//  command  | start, busy        | kind, vertex_index, pos_*, start_n*, corner_*
//  result   | done (strobe)      | out_index, unit_nx, unit_ny, unit_nz, zero_sum
//
// A load word is written at its accept edge and leaves busy low. A triangle runs fetch,
// cross product on the one shared multiplier, magnitude, scaling shifts, squares, the
// bit-serial square root and the bit-serial divider, then read-modify-write; a zero face
// normal ends it after magnitude. A read loads its sum and runs the same steps up to the
// divider, or stops after magnitude for a zero sum; its done strobe comes as busy drops.
// Reset clears only the sequencer; the memories are undefined until written.
module vertex_normal_accumulator_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         kind,
	input  logic [9:0]         vertex_index,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic signed [23:0] pos_z,
	input  logic signed [15:0] start_nx,
	input  logic signed [15:0] start_ny,
	input  logic signed [15:0] start_nz,
	input  logic [9:0]         corner_a,
	input  logic [9:0]         corner_b,
	input  logic [9:0]         corner_c,
	output logic               done,
	output logic [9:0]         out_index,
	output logic signed [15:0] unit_nx,
	output logic signed [15:0] unit_ny,
	output logic signed [15:0] unit_nz,
	output logic               zero_sum
);

	vna_pkg::state_t state_q, state_d;
	logic done_q;

	logic              is_tri_q;
	logic [9:0]        idx_q, ca_q, cb_q, cc_q;
	vna_pkg::vec3_t    pa_q;
	logic signed [24:0] e1_q [3];
	logic signed [24:0] e2_q [3];
	logic signed [50:0] vec_q [3];
	logic [49:0]       m_q [3];
	logic              neg_q [3];
	logic signed [15:0] unit_q [3];
	logic              zero_q;
	logic [3:0]        cnt_q;
	logic [1:0]        comp_q;
	logic [61:0]       sq_q, n_q, r_q, bit_q;
	logic [44:0]       rem_q;
	logic [14:0]       q_q;

	vna_pkg::store_req_t req;
	vna_pkg::vec3_t      pos_rd_q, sum_rd_q;
	logic signed [30:0]  mul_a, mul_b;
	logic signed [61:0]  prod_q;

	logic accept;
	logic [61:0] root_trial;
	logic [30:0] lenv;
	logic [44:0] dvs;
	logic        div_ge;
	logic [14:0] qv;
	logic [1:0]  vj;
	logic [9:0]  rmw_idx;

	assign accept = start && !busy;
	assign busy = (state_q != vna_pkg::ST_IDLE);

	vna_store u_store (.clk(clk), .req(req), .pos_rd_q(pos_rd_q), .sum_rd_q(sum_rd_q));
	vna_mul   u_mul   (.clk(clk), .a(mul_a), .b(mul_b), .p_q(prod_q));

	assign root_trial = r_q + bit_q;
	assign lenv   = (r_q == 62'd0) ? 31'd1 : r_q[30:0];
	assign dvs    = 45'(lenv) << cnt_q;
	assign div_ge = (rem_q >= dvs);
	assign qv     = div_ge ? (q_q | (15'd1 << cnt_q)) : q_q;
	assign vj     = 2'((cnt_q - 4'd1) >> 1);

	always_comb begin
		unique case (cnt_q[1:0])
			2'd0:    rmw_idx = ca_q;
			2'd1:    rmw_idx = cb_q;
			default: rmw_idx = cc_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vna_pkg::ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == vna_pkg::ST_DIV) && (state_d == vna_pkg::ST_IDLE) && !is_tri_q
				|| (state_q == vna_pkg::ST_MAG) && (state_d == vna_pkg::ST_IDLE) && !is_tri_q;
		end
	end

	// Next state, memory requests and multiplier operands.
	always_comb begin
		state_d = state_q;
		req = '0;
		mul_a = '0;
		mul_b = '0;
		req.pos_raddr = ca_q;
		req.sum_raddr = idx_q;
		req.sum_waddr = rmw_idx;
		req.sum_wdata.x = vna_pkg::sat_add(sum_rd_q.x, unit_q[0]);
		req.sum_wdata.y = vna_pkg::sat_add(sum_rd_q.y, unit_q[1]);
		req.sum_wdata.z = vna_pkg::sat_add(sum_rd_q.z, unit_q[2]);
		unique case (state_q)
			vna_pkg::ST_IDLE: begin
				req.pos_waddr = vertex_index;
				req.pos_wdata = {pos_x, pos_y, pos_z};
				if (accept && kind == vna_pkg::KIND_LOAD && vna_pkg::idx_ok(vertex_index)) begin
					req.pos_we = 1'b1;
					req.sum_we = 1'b1;
					req.sum_waddr = vertex_index;
					req.sum_wdata = {24'(start_nx), 24'(start_ny), 24'(start_nz)};
				end
				if (accept && kind == vna_pkg::KIND_TRI) begin
					if (vna_pkg::idx_ok(corner_a) && vna_pkg::idx_ok(corner_b)
						&& vna_pkg::idx_ok(corner_c)) begin
						state_d = vna_pkg::ST_RDA;
					end
				end else if (accept && kind == vna_pkg::KIND_READ) begin
					state_d = vna_pkg::ST_RDS;
				end
			end
			vna_pkg::ST_RDA: begin
				req.pos_raddr = ca_q;
				state_d = vna_pkg::ST_RDB;
			end
			vna_pkg::ST_RDB: begin
				req.pos_raddr = cb_q;
				state_d = vna_pkg::ST_RDC;
			end
			vna_pkg::ST_RDC: begin
				req.pos_raddr = cc_q;
				state_d = vna_pkg::ST_EDGE;
			end
			vna_pkg::ST_EDGE: state_d = vna_pkg::ST_CROSS;
			vna_pkg::ST_CROSS: begin
				unique case (cnt_q)
					4'd0: begin mul_a = 31'(e1_q[1]); mul_b = 31'(e2_q[2]); end
					4'd1: begin mul_a = 31'(e1_q[2]); mul_b = 31'(e2_q[1]); end
					4'd2: begin mul_a = 31'(e1_q[2]); mul_b = 31'(e2_q[0]); end
					4'd3: begin mul_a = 31'(e1_q[0]); mul_b = 31'(e2_q[2]); end
					4'd4: begin mul_a = 31'(e1_q[0]); mul_b = 31'(e2_q[1]); end
					4'd5: begin mul_a = 31'(e1_q[1]); mul_b = 31'(e2_q[0]); end
					default: ;
				endcase
				if (cnt_q == 4'd6) state_d = vna_pkg::ST_MAG;
			end
			vna_pkg::ST_RDS: state_d = vna_pkg::ST_LDS;
			vna_pkg::ST_LDS: state_d = vna_pkg::ST_MAG;
			vna_pkg::ST_MAG: begin
				if (vec_q[0] == '0 && vec_q[1] == '0 && vec_q[2] == '0) begin
					state_d = vna_pkg::ST_IDLE;
				end else begin
					state_d = vna_pkg::ST_SHIFT;
				end
			end
			vna_pkg::ST_SHIFT: begin
				if (m_q[0][49:30] == '0 && m_q[1][49:30] == '0 && m_q[2][49:30] == '0) begin
					state_d = vna_pkg::ST_SQ;
				end
			end
			vna_pkg::ST_SQ: begin
				if (cnt_q < 4'd3) begin
					mul_a = $signed({1'b0, m_q[cnt_q[1:0]][29:0]});
					mul_b = $signed({1'b0, m_q[cnt_q[1:0]][29:0]});
				end else begin
					state_d = vna_pkg::ST_SQRT;
				end
			end
			vna_pkg::ST_SQRT: if (bit_q[0]) state_d = vna_pkg::ST_DINIT;
			vna_pkg::ST_DINIT: state_d = vna_pkg::ST_DIV;
			vna_pkg::ST_DIV: begin
				if (cnt_q == 4'd0) begin
					if (comp_q != 2'd2) state_d = vna_pkg::ST_DINIT;
					else if (is_tri_q) state_d = vna_pkg::ST_RMW_RD;
					else state_d = vna_pkg::ST_IDLE;
				end
			end
			vna_pkg::ST_RMW_RD: begin
				req.sum_raddr = rmw_idx;
				state_d = vna_pkg::ST_RMW_WR;
			end
			vna_pkg::ST_RMW_WR: begin
				req.sum_we = 1'b1;
				state_d = (cnt_q == 4'd2) ? vna_pkg::ST_IDLE : vna_pkg::ST_RMW_RD;
			end
			default: state_d = vna_pkg::ST_IDLE;
		endcase
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			vna_pkg::ST_IDLE: begin
				is_tri_q <= (kind == vna_pkg::KIND_TRI);
				idx_q <= vertex_index;
				ca_q  <= corner_a;
				cb_q  <= corner_b;
				cc_q  <= corner_c;
				cnt_q <= '0;
			end
			vna_pkg::ST_RDB: pa_q <= pos_rd_q;
			vna_pkg::ST_RDC: begin
				e1_q[0] <= 25'(pos_rd_q.x) - 25'(pa_q.x);
				e1_q[1] <= 25'(pos_rd_q.y) - 25'(pa_q.y);
				e1_q[2] <= 25'(pos_rd_q.z) - 25'(pa_q.z);
			end
			vna_pkg::ST_EDGE: begin
				e2_q[0] <= 25'(pos_rd_q.x) - 25'(pa_q.x);
				e2_q[1] <= 25'(pos_rd_q.y) - 25'(pa_q.y);
				e2_q[2] <= 25'(pos_rd_q.z) - 25'(pa_q.z);
				cnt_q <= '0;
			end
			vna_pkg::ST_CROSS: begin
				// Even products start a component, odd ones are subtracted from it.
				if (cnt_q != 4'd0) begin
					if (cnt_q[0]) vec_q[vj] <= 51'(prod_q);
					else vec_q[vj] <= vec_q[vj] - 51'(prod_q);
				end
				cnt_q <= cnt_q + 4'd1;
			end
			vna_pkg::ST_LDS: begin
				if (vna_pkg::idx_ok(idx_q)) begin
					vec_q[0] <= 51'(sum_rd_q.x);
					vec_q[1] <= 51'(sum_rd_q.y);
					vec_q[2] <= 51'(sum_rd_q.z);
				end else begin
					vec_q[0] <= '0;
					vec_q[1] <= '0;
					vec_q[2] <= '0;
				end
			end
			vna_pkg::ST_MAG: begin
				for (int i = 0; i < 3; i++) begin
					neg_q[i]  <= vec_q[i][50];
					m_q[i]    <= vec_q[i][50] ? 50'(-vec_q[i]) : 50'(vec_q[i]);
					unit_q[i] <= '0;
				end
				zero_q <= (vec_q[0] == '0 && vec_q[1] == '0 && vec_q[2] == '0);
			end
			vna_pkg::ST_SHIFT: begin
				if (!(m_q[0][49:30] == '0 && m_q[1][49:30] == '0 && m_q[2][49:30] == '0)) begin
					for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
				end
				cnt_q <= '0;
			end
			vna_pkg::ST_SQ: begin
				if (cnt_q == 4'd1) sq_q <= $unsigned(prod_q);
				else if (cnt_q == 4'd2) sq_q <= sq_q + $unsigned(prod_q);
				if (cnt_q == 4'd3) begin
					n_q   <= sq_q + $unsigned(prod_q);
					r_q   <= '0;
					bit_q <= 62'd1 << 60;
				end
				cnt_q <= cnt_q + 4'd1;
				comp_q <= '0;
			end
			vna_pkg::ST_SQRT: begin
				if (n_q >= root_trial) begin
					n_q <= n_q - root_trial;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			vna_pkg::ST_DINIT: begin
				rem_q <= {1'b0, m_q[comp_q][29:0], 14'd0} + 45'(lenv >> 1);
				q_q   <= '0;
				cnt_q <= 4'd14;
			end
			vna_pkg::ST_DIV: begin
				if (div_ge) rem_q <= rem_q - dvs;
				q_q <= qv;
				if (cnt_q == 4'd0) begin
					unit_q[comp_q] <= neg_q[comp_q] ? -16'(qv) : 16'(qv);
					comp_q <= comp_q + 2'd1;
				end else begin
					cnt_q <= cnt_q - 4'd1;
				end
			end
			vna_pkg::ST_RMW_WR: cnt_q <= cnt_q + 4'd1;
			default: ;
		endcase
		if (state_q == vna_pkg::ST_DIV && cnt_q == 4'd0 && comp_q == 2'd2) cnt_q <= '0;
	end

	assign done      = done_q;
	assign out_index = idx_q;
	assign unit_nx   = unit_q[0];
	assign unit_ny   = unit_q[1];
	assign unit_nz   = unit_q[2];
	assign zero_sum  = zero_q;

endmodule

[rtl/vna_checker.sv]
// Port-level checker for the vertex normal accumulator, bound to the top level.
module vna_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [1:0]         kind,
	input logic               done,
	input logic signed [15:0] unit_nx,
	input logic signed [15:0] unit_ny,
	input logic signed [15:0] unit_nz,
	input logic               zero_sum
);

	// A result word appears exactly once, as the sequencer drops back to idle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done strobe longer than one cycle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result word while still busy");

	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && kind == vna_pkg::KIND_READ |=> busy)
		else $error("read command did not start the sequencer");

	a_load_fast: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (kind == vna_pkg::KIND_LOAD || kind == vna_pkg::KIND_NONE)
		|=> !busy && !done) else $error("load or unknown command occupied the block");

	a_zero_word: assert property (@(posedge clk) disable iff (!arst_n)
		done && zero_sum |-> unit_nx == 16'sd0 && unit_ny == 16'sd0 && unit_nz == 16'sd0)
		else $error("zero sum flagged with a nonzero normal");

endmodule

bind vertex_normal_accumulator_top vna_checker u_vna_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind), .done(done),
	.unit_nx(unit_nx), .unit_ny(unit_ny), .unit_nz(unit_nz), .zero_sum(zero_sum)
);
